/* design/swmv_pkg.sv */
// ----------------------------------------------------------------------------
// swmv_pkg
// Types and fixed widths shared by the sliding window mean and variance block.
// ----------------------------------------------------------------------------
`default_nettype none

package swmv_pkg;

    localparam int SAMPLE_W = 16;
    localparam int VAR_W    = 31;
    localparam int QUO_W    = 31;
    localparam int SQUARE_W = 31;

    // Register stages in the constant divider: partial products, then their sum.
    localparam int DIV_LAT  = 2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] angle_sample;
        logic signed [SAMPLE_W-1:0] rate_sample;
    } swmv_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] angle_mean;
        logic        [VAR_W-1:0]    angle_variance;
        logic signed [SAMPLE_W-1:0] rate_mean;
        logic        [VAR_W-1:0]    rate_variance;
    } swmv_out_t;

    typedef struct packed {
        logic en;
        logic sum_upd;
        logic sq_upd;
    } swmv_ctrl_t;

endpackage

`default_nettype wire

/* design/swmv_if.sv */
// ----------------------------------------------------------------------------
// swmv_if
// Valid/ready stream interfaces for the sample input and the statistics output.
// ----------------------------------------------------------------------------
`default_nettype none

interface swmv_in_if;
    logic               valid;
    logic               ready;
    swmv_pkg::swmv_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface swmv_out_if;
    logic                valid;
    logic                ready;
    swmv_pkg::swmv_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/swmv_ring.sv */
// ----------------------------------------------------------------------------
// swmv_ring
// Sample ring memory: writes the new pair and reads the pair it replaces.
// ----------------------------------------------------------------------------
`default_nettype none

module swmv_ring #(
    parameter int WINDOW = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  swmv_pkg::swmv_in_t sample,
    output swmv_pkg::swmv_in_t cur,
    output swmv_pkg::swmv_in_t old
);

    localparam int SLOT_W = $clog2(WINDOW);

    swmv_pkg::swmv_in_t mem [WINDOW];
    swmv_pkg::swmv_in_t rd_reg;
    swmv_pkg::swmv_in_t cur_reg;

    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [WINDOW-1:0] filled_reg;
    logic              old_valid_reg;

    // Entries never written read as zero through the filled bits.
    assign slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            filled_reg    <= '0;
            old_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            slot_reg             <= slot_next;
            filled_reg[slot_reg] <= 1'b1;
            old_valid_reg        <= filled_reg[slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg        <= mem[slot_reg];
            mem[slot_reg] <= sample;
            cur_reg       <= sample;
        end
    end

    assign cur = cur_reg;
    assign old = old_valid_reg ? rd_reg : '0;

endmodule

`default_nettype wire

/* design/swmv_cdiv.sv */
// ----------------------------------------------------------------------------
// swmv_cdiv
// Division by a constant through a reciprocal multiplication in two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module swmv_cdiv #(
    parameter int NUM_W   = 37,
    parameter int QUO_W   = 31,
    parameter int DIVISOR = 25
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    output logic [QUO_W-1:0] quo
);

    localparam int HALF_W = (NUM_W + 2) / 2;
    localparam int SHIFT  = NUM_W + $clog2(DIVISOR);
    localparam int PROD_W = 4 * HALF_W;

    // The rounded-up reciprocal gives the exact floor for every NUM_W-bit numerator.
    localparam logic [2*HALF_W-1:0] RECIP =
        (2*HALF_W)'(((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));
    localparam logic [HALF_W-1:0] RECIP_LO = RECIP[HALF_W-1:0];
    localparam logic [HALF_W-1:0] RECIP_HI = RECIP[2*HALF_W-1:HALF_W];

    logic [HALF_W-1:0]   num_lo;
    logic [HALF_W-1:0]   num_hi;
    logic [2*HALF_W-1:0] ll_reg;
    logic [2*HALF_W-1:0] lh_reg;
    logic [2*HALF_W-1:0] hl_reg;
    logic [2*HALF_W-1:0] hh_reg;
    logic [PROD_W-1:0]   prod;
    logic [QUO_W-1:0]    quo_reg;

    assign num_lo = num[HALF_W-1:0];
    assign num_hi = HALF_W'(num >> HALF_W);

    assign prod = PROD_W'(ll_reg)
                + (PROD_W'(lh_reg) << HALF_W)
                + (PROD_W'(hl_reg) << HALF_W)
                + (PROD_W'(hh_reg) << (2 * HALF_W));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg  <= num_lo * RECIP_LO;
            lh_reg  <= num_lo * RECIP_HI;
            hl_reg  <= num_hi * RECIP_LO;
            hh_reg  <= num_hi * RECIP_HI;
            quo_reg <= QUO_W'(prod >> SHIFT);
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

/* design/swmv_accum.sv */
// ----------------------------------------------------------------------------
// swmv_accum
// Running sum and sum of squares of one signal, with mean and variance.
// ----------------------------------------------------------------------------
`default_nettype none

module swmv_accum #(
    parameter int WINDOW = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  swmv_pkg::swmv_ctrl_t                 ctrl,
    input  logic signed [swmv_pkg::SAMPLE_W-1:0] new_sample,
    input  logic signed [swmv_pkg::SAMPLE_W-1:0] old_sample,
    output logic signed [swmv_pkg::SAMPLE_W-1:0] mean,
    output logic        [swmv_pkg::VAR_W-1:0]    variance
);

    localparam int WIN_W = $clog2(WINDOW);
    localparam int SUM_W = swmv_pkg::SAMPLE_W + WIN_W;
    localparam int SQS_W = swmv_pkg::SQUARE_W + WIN_W;
    localparam int LHS_W = 2 * WIN_W + swmv_pkg::SQUARE_W;
    localparam int QW    = swmv_pkg::QUO_W;

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum3_reg;
    logic [SQS_W-1:0]        sq_sum_reg;
    logic [swmv_pkg::SQUARE_W-1:0] sq_new_reg;
    logic [swmv_pkg::SQUARE_W-1:0] sq_old_reg;
    logic signed [2*swmv_pkg::SAMPLE_W-1:0] sq_new_full;
    logic signed [2*swmv_pkg::SAMPLE_W-1:0] sq_old_full;

    logic [SUM_W-1:0]   mag3;
    logic [2*SUM_W-1:0] rhs_full;
    logic [LHS_W-1:0]   lhs_reg;
    logic [LHS_W-1:0]   rhs_reg;
    logic [SUM_W-1:0]   mag4_reg;
    logic               neg4_reg;

    logic [LHS_W-1:0]   var_num_reg;
    logic [LHS_W-1:0]   mean_num_reg;
    logic               neg5_reg;
    logic [swmv_pkg::DIV_LAT-1:0] neg_pipe_reg;

    logic [QW-1:0] mean_q;
    logic [QW-1:0] var_q;

    assign sum_next    = sum_reg + SUM_W'(new_sample) - SUM_W'(old_sample);
    assign sq_new_full = new_sample * new_sample;
    assign sq_old_full = old_sample * old_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            sq_sum_reg <= '0;
        end
        else if (ctrl.en)
        begin
            if (ctrl.sum_upd)
            begin
                sum_reg <= sum_next;
            end
            if (ctrl.sq_upd)
            begin
                sq_sum_reg <= sq_sum_reg + SQS_W'(sq_new_reg) - SQS_W'(sq_old_reg);
            end
        end
    end

    assign mag3     = sum3_reg[SUM_W-1] ? $unsigned(-sum3_reg) : $unsigned(sum3_reg);
    assign rhs_full = mag3 * mag3;

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            sq_new_reg   <= sq_new_full[swmv_pkg::SQUARE_W-1:0];
            sq_old_reg   <= sq_old_full[swmv_pkg::SQUARE_W-1:0];
            sum3_reg     <= sum_reg;
            lhs_reg      <= LHS_W'(sq_sum_reg) * LHS_W'(WINDOW);
            rhs_reg      <= rhs_full[LHS_W-1:0];
            mag4_reg     <= mag3;
            neg4_reg     <= sum3_reg[SUM_W-1];
            var_num_reg  <= (lhs_reg > rhs_reg) ? lhs_reg - rhs_reg : '0;
            mean_num_reg <= LHS_W'(mag4_reg);
            neg5_reg     <= neg4_reg;
            neg_pipe_reg <= {neg_pipe_reg[swmv_pkg::DIV_LAT-2:0], neg5_reg};
        end
    end

    swmv_cdiv #(
        .NUM_W   (LHS_W),
        .QUO_W   (QW),
        .DIVISOR (WINDOW)
    ) u_mean_div (
        .clk (clk),
        .en  (ctrl.en),
        .num (mean_num_reg),
        .quo (mean_q)
    );

    swmv_cdiv #(
        .NUM_W   (LHS_W),
        .QUO_W   (QW),
        .DIVISOR (WINDOW * WINDOW)
    ) u_var_div (
        .clk (clk),
        .en  (ctrl.en),
        .num (var_num_reg),
        .quo (var_q)
    );

    // The mean truncates toward zero, so the magnitude is divided and the sign restored.
    assign mean     = neg_pipe_reg[swmv_pkg::DIV_LAT-1]
                    ? -$signed(mean_q[swmv_pkg::SAMPLE_W-1:0])
                    : $signed(mean_q[swmv_pkg::SAMPLE_W-1:0]);
    assign variance = var_q[swmv_pkg::VAR_W-1:0];

endmodule

`default_nettype wire

/* design/sliding_window_mean_variance.sv */
// ----------------------------------------------------------------------------
// sliding_window_mean_variance
// Mean and variance of angle and rate samples over the last WINDOW pairs.
//
// Each transfer on the samples channel carries one angle and one rate sample.
// For every accepted pair one result transfer leaves on the stats channel,
// in order, with the window mean and variance of both signals.
// The block accepts one pair per cycle while the skid register is empty.
// The edge that accepts a pair writes the ring memory and reads the replaced
// entry; then registers compute the sums, squares and numerators, the divider
// stages divide by the window constants through reciprocal multiplication,
// and finally the result is loaded into the output register.
// After reset the ring reads as all zero, so the first windows count zeros.
// When the receiver stalls, the next result goes to a skid register behind
// the output register and the pipeline freezes while that register is full;
// samples.ready is low from the edge that fills it until a result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_mean_variance #(
    parameter int WINDOW = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    swmv_in_if.sink           samples,
    swmv_out_if.source        stats
);

    localparam int DEPTH = 5 + swmv_pkg::DIV_LAT;

    swmv_pkg::swmv_ctrl_t ctrl;
    swmv_pkg::swmv_in_t   cur;
    swmv_pkg::swmv_in_t   old;
    swmv_pkg::swmv_out_t  result;
    swmv_pkg::swmv_out_t  out_reg;
    swmv_pkg::swmv_out_t  skid_reg;

    logic [DEPTH-1:0] vld_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             en;
    logic             accept;
    logic             done;
    logic             out_fire;

    assign en       = !skid_valid_reg;
    assign accept   = samples.valid && en;
    assign done     = en && vld_reg[DEPTH-1];
    assign out_fire = out_valid_reg && stats.ready;

    assign ctrl.en      = en;
    assign ctrl.sum_upd = vld_reg[0];
    assign ctrl.sq_upd  = vld_reg[1];

    swmv_ring #(
        .WINDOW (WINDOW)
    ) u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (samples.payload),
        .cur    (cur),
        .old    (old)
    );

    swmv_accum #(
        .WINDOW (WINDOW)
    ) u_angle (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_sample (cur.angle_sample),
        .old_sample (old.angle_sample),
        .mean       (result.angle_mean),
        .variance   (result.angle_variance)
    );

    swmv_accum #(
        .WINDOW (WINDOW)
    ) u_rate (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_sample (cur.rate_sample),
        .old_sample (old.rate_sample),
        .mean       (result.rate_mean),
        .variance   (result.rate_variance)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[DEPTH-2:0], accept};
            end
            if (skid_valid_reg)
            begin
                if (out_fire)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (done)
            begin
                if (out_valid_reg && !out_fire)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (done)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign samples.ready = en;
    assign stats.valid   = out_valid_reg;
    assign stats.payload = out_reg;

endmodule

`default_nettype wire
